FILE: rtl/lkc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkc_pkg
// Shared constants, request codes and the control/status bundles between
// the controller and the datapath of the keyed lru cache directory.
// ----------------------------------------------------------------------------
package lkc_pkg;

    localparam int SLOTS_DEF        = 16;
    localparam int KEY_WIDTH_DEF    = 32;
    localparam int HANDLE_WIDTH_DEF = 16;
    localparam int LEN_WIDTH        = 22;
    localparam int MODE_WIDTH       = 2;
    localparam int STAMP_WIDTH      = 32;

    localparam logic [MODE_WIDTH-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_GET   = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_FLUSH = 2'd2;

    typedef struct packed {
        logic load_req;
        logic lookup;
        logic scan_start;
        logic scan_step;
        logic rd_victim;
        logic flush_pick;
        logic put_commit;
        logic get_commit;
        logic flush_commit;
        logic zero_commit;
    } lkc_cmd_t;

    typedef struct packed {
        logic [MODE_WIDTH-1:0] mode;
        logic                  hit;
        logic                  scan_done;
        logic                  flush_pending;
        logic                  out_free;
    } lkc_sts_t;

endpackage
`default_nettype wire

FILE: rtl/lkc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkc_ctrl
// Sequencer for put, get and flush requests: steps the datapath through
// lookup, victim scan, slot read and result hand-off.
// ----------------------------------------------------------------------------
module lkc_ctrl
    import lkc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire lkc_sts_t sts,
    output lkc_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_SCAN,
        ST_PUT_READ,
        ST_PUT_EMIT,
        ST_GET_EMIT,
        ST_FL_FIND,
        ST_FL_EMIT,
        ST_ZERO_EMIT
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    assign s_tready = ready_reg;

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:      cmd.load_req = s_tvalid;
            ST_LOOKUP:    cmd.lookup = 1'b1;
            ST_DECIDE:
            begin
                case (sts.mode)
                    MODE_PUT:
                    begin
                        cmd.rd_victim  = sts.hit;
                        cmd.scan_start = !sts.hit;
                    end
                    MODE_GET:     cmd.rd_victim = sts.hit;
                    MODE_FLUSH:   cmd.flush_pick = sts.flush_pending;
                    default:      cmd.lookup = 1'b0;
                endcase
            end
            ST_SCAN:      cmd.scan_step = 1'b1;
            ST_PUT_READ:  cmd.rd_victim = 1'b1;
            ST_PUT_EMIT:  cmd.put_commit = sts.out_free;
            ST_GET_EMIT:  cmd.get_commit = sts.out_free;
            ST_FL_FIND:   cmd.flush_pick = sts.flush_pending;
            ST_FL_EMIT:   cmd.flush_commit = sts.out_free;
            ST_ZERO_EMIT: cmd.zero_commit = sts.out_free;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_LOOKUP;
                        ready_reg <= 1'b0;
                    end
                end
                ST_LOOKUP:    state_reg <= ST_DECIDE;
                ST_DECIDE:
                begin
                    case (sts.mode)
                        MODE_PUT:   state_reg <= sts.hit ? ST_PUT_EMIT : ST_SCAN;
                        MODE_GET:   state_reg <= sts.hit ? ST_GET_EMIT : ST_ZERO_EMIT;
                        MODE_FLUSH: state_reg <= sts.flush_pending ? ST_FL_EMIT
                                                                   : ST_ZERO_EMIT;
                        default:    state_reg <= ST_ZERO_EMIT;
                    endcase
                end
                ST_SCAN:
                begin
                    if (sts.scan_done)
                    begin
                        state_reg <= ST_PUT_READ;
                    end
                end
                ST_PUT_READ:  state_reg <= ST_PUT_EMIT;
                ST_FL_FIND:
                begin
                    if (sts.flush_pending)
                    begin
                        state_reg <= ST_FL_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                ST_FL_EMIT:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= ST_FL_FIND;
                    end
                end
                ST_PUT_EMIT, ST_GET_EMIT, ST_ZERO_EMIT:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lkc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lkc_datapath
// Slot directory (keys, stamps, valid and dirty bits in flops, handle and
// length in a memory), key match, lru scan, flush mask and result register.
// ----------------------------------------------------------------------------
module lkc_datapath
    import lkc_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int KEY_WIDTH    = KEY_WIDTH_DEF,
    parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lkc_cmd_t                cmd,
    output lkc_sts_t                     sts,
    input  wire logic [MODE_WIDTH-1:0]   in_mode,
    input  wire logic [KEY_WIDTH-1:0]    in_key,
    input  wire logic [HANDLE_WIDTH-1:0] in_handle,
    input  wire logic [LEN_WIDTH-1:0]    in_length,
    input  wire logic                    out_ready,
    output logic                         out_valid,
    output logic                         out_hit,
    output logic                         out_entry_valid,
    output logic [KEY_WIDTH-1:0]         out_key,
    output logic [HANDLE_WIDTH-1:0]      out_handle,
    output logic [LEN_WIDTH-1:0]         out_length,
    output logic                         out_evicted_valid,
    output logic                         out_evicted_dirty,
    output logic [HANDLE_WIDTH-1:0]      out_evicted_handle,
    output logic                         out_last
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int MEM_W = HANDLE_WIDTH + LEN_WIDTH;

    logic [MODE_WIDTH-1:0]   req_mode_reg;
    logic [KEY_WIDTH-1:0]    req_key_reg;
    logic [HANDLE_WIDTH-1:0] req_handle_reg;
    logic [LEN_WIDTH-1:0]    req_length_reg;

    logic [KEY_WIDTH-1:0]    slot_key_reg   [SLOTS];
    logic [STAMP_WIDTH-1:0]  slot_stamp_reg [SLOTS];
    logic [SLOTS-1:0]        slot_valid_reg;
    logic [SLOTS-1:0]        slot_dirty_reg;
    logic [STAMP_WIDTH-1:0]  stamp_cnt_reg;
    logic [SLOTS-1:0]        flush_mask_reg;

    logic [MEM_W-1:0]        slot_mem [SLOTS];
    logic [MEM_W-1:0]        rdata_reg;

    logic                    hit_reg;
    logic [IDX_W-1:0]        victim_reg;
    logic [IDX_W-1:0]        scan_idx_reg;
    logic [STAMP_WIDTH-1:0]  best_stamp_reg;

    logic                    out_valid_reg;
    logic                    out_hit_reg;
    logic                    out_entry_valid_reg;
    logic [KEY_WIDTH-1:0]    out_key_reg;
    logic [HANDLE_WIDTH-1:0] out_handle_reg;
    logic [LEN_WIDTH-1:0]    out_length_reg;
    logic                    out_ev_valid_reg;
    logic                    out_ev_dirty_reg;
    logic [HANDLE_WIDTH-1:0] out_ev_handle_reg;
    logic                    out_last_reg;

    logic [SLOTS-1:0]        match_vec;
    logic [IDX_W-1:0]        match_idx;
    logic [IDX_W-1:0]        pick_idx;
    logic [IDX_W-1:0]        rd_addr;
    logic [SLOTS-1:0]        victim_onehot;
    logic [SLOTS-1:0]        mask_rest;
    logic [STAMP_WIDTH-1:0]  stamp_next;
    logic [STAMP_WIDTH-1:0]  cur_stamp;
    logic [HANDLE_WIDTH-1:0] rd_handle;
    logic [LEN_WIDTH-1:0]    rd_length;
    logic                    victim_valid;
    logic                    victim_dirty;
    logic                    any_commit;

    always_comb
    begin
        match_idx = '0;
        pick_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            match_vec[i] = slot_valid_reg[i] && (slot_key_reg[i] == req_key_reg);
            if (match_vec[i])
            begin
                match_idx = IDX_W'(i);
            end
            if (flush_mask_reg[i])
            begin
                pick_idx = IDX_W'(i);
            end
        end
    end

    assign victim_onehot = {{(SLOTS-1){1'b0}}, 1'b1} << victim_reg;
    assign mask_rest     = flush_mask_reg & ~victim_onehot;
    assign stamp_next    = stamp_cnt_reg + STAMP_WIDTH'(1);
    assign cur_stamp     = slot_stamp_reg[scan_idx_reg];
    assign rd_addr       = cmd.flush_pick ? pick_idx : victim_reg;
    assign rd_handle     = rdata_reg[HANDLE_WIDTH-1:0];
    assign rd_length     = rdata_reg[MEM_W-1:HANDLE_WIDTH];
    assign victim_valid  = slot_valid_reg[victim_reg];
    assign victim_dirty  = slot_dirty_reg[victim_reg];
    assign any_commit    = cmd.put_commit || cmd.get_commit || cmd.flush_commit
                           || cmd.zero_commit;

    assign sts.mode          = req_mode_reg;
    assign sts.hit           = hit_reg;
    assign sts.scan_done     = (scan_idx_reg == IDX_W'(SLOTS - 1));
    assign sts.flush_pending = |flush_mask_reg;
    assign sts.out_free      = !out_valid_reg || out_ready;

    // handle and length store
    always_ff @(posedge clk)
    begin
        if (cmd.put_commit)
        begin
            slot_mem[victim_reg] <= {req_length_reg, req_handle_reg};
        end
        if (cmd.rd_victim || cmd.flush_pick)
        begin
            rdata_reg <= slot_mem[rd_addr];
        end
    end

    // slot state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_stamp_reg[i] <= '0;
            end
            slot_valid_reg <= '0;
            slot_dirty_reg <= '0;
            stamp_cnt_reg  <= '0;
            flush_mask_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.lookup)
            begin
                flush_mask_reg <= slot_valid_reg & slot_dirty_reg;
            end
            if (cmd.put_commit)
            begin
                slot_stamp_reg[victim_reg] <= stamp_next;
                slot_valid_reg[victim_reg] <= 1'b1;
                slot_dirty_reg[victim_reg] <= 1'b1;
                stamp_cnt_reg              <= stamp_next;
            end
            if (cmd.get_commit)
            begin
                slot_stamp_reg[victim_reg] <= stamp_next;
                stamp_cnt_reg              <= stamp_next;
            end
            if (cmd.flush_commit)
            begin
                slot_dirty_reg[victim_reg] <= 1'b0;
                flush_mask_reg             <= mask_rest;
            end
            if (any_commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request, working and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_mode_reg   <= in_mode;
            req_key_reg    <= in_key;
            req_handle_reg <= in_handle;
            req_length_reg <= in_length;
        end
        if (cmd.lookup)
        begin
            hit_reg    <= |match_vec;
            victim_reg <= match_idx;
        end
        if (cmd.scan_start)
        begin
            victim_reg     <= '0;
            best_stamp_reg <= slot_stamp_reg[0];
            scan_idx_reg   <= IDX_W'(1);
        end
        if (cmd.scan_step)
        begin
            if (cur_stamp < best_stamp_reg)
            begin
                victim_reg     <= scan_idx_reg;
                best_stamp_reg <= cur_stamp;
            end
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        if (cmd.flush_pick)
        begin
            victim_reg <= pick_idx;
        end
        if (cmd.put_commit)
        begin
            slot_key_reg[victim_reg] <= req_key_reg;
        end

        if (cmd.put_commit)
        begin
            out_hit_reg         <= hit_reg;
            out_entry_valid_reg <= 1'b0;
            out_key_reg         <= '0;
            out_handle_reg      <= '0;
            out_length_reg      <= '0;
            out_ev_valid_reg    <= victim_valid;
            out_ev_dirty_reg    <= victim_valid && victim_dirty;
            out_ev_handle_reg   <= victim_valid ? rd_handle : '0;
            out_last_reg        <= 1'b1;
        end
        else if (cmd.get_commit)
        begin
            out_hit_reg         <= 1'b1;
            out_entry_valid_reg <= 1'b1;
            out_key_reg         <= req_key_reg;
            out_handle_reg      <= rd_handle;
            out_length_reg      <= rd_length;
            out_ev_valid_reg    <= 1'b0;
            out_ev_dirty_reg    <= 1'b0;
            out_ev_handle_reg   <= '0;
            out_last_reg        <= 1'b1;
        end
        else if (cmd.flush_commit)
        begin
            out_hit_reg         <= 1'b0;
            out_entry_valid_reg <= 1'b1;
            out_key_reg         <= slot_key_reg[victim_reg];
            out_handle_reg      <= rd_handle;
            out_length_reg      <= rd_length;
            out_ev_valid_reg    <= 1'b0;
            out_ev_dirty_reg    <= 1'b0;
            out_ev_handle_reg   <= '0;
            out_last_reg        <= (mask_rest == '0);
        end
        else if (cmd.zero_commit)
        begin
            out_hit_reg         <= 1'b0;
            out_entry_valid_reg <= 1'b0;
            out_key_reg         <= '0;
            out_handle_reg      <= '0;
            out_length_reg      <= '0;
            out_ev_valid_reg    <= 1'b0;
            out_ev_dirty_reg    <= 1'b0;
            out_ev_handle_reg   <= '0;
            out_last_reg        <= 1'b1;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_hit            = out_hit_reg;
    assign out_entry_valid    = out_entry_valid_reg;
    assign out_key            = out_key_reg;
    assign out_handle         = out_handle_reg;
    assign out_length         = out_length_reg;
    assign out_evicted_valid  = out_ev_valid_reg;
    assign out_evicted_dirty  = out_ev_dirty_reg;
    assign out_evicted_handle = out_ev_handle_reg;
    assign out_last           = out_last_reg;

`ifndef SYNTHESIS
    a_mask_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (flush_mask_reg & ~(slot_valid_reg & slot_dirty_reg)) == '0)
        else $error("flush mask holds a slot that is not valid and dirty");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        any_commit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_put_marks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put_commit |=> (slot_valid_reg[$past(victim_reg)]
                            && slot_dirty_reg[$past(victim_reg)]))
        else $error("put left its slot invalid or clean");

    a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put_commit || cmd.get_commit)
            |=> stamp_cnt_reg == $past(stamp_cnt_reg) + STAMP_WIDTH'(1))
        else $error("stamp counter did not advance by one");
`endif

endmodule
`default_nettype wire

FILE: rtl/lru_keyed_cache_with_dirty_flush_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_keyed_cache_with_dirty_flush_core
// Fully associative cache directory with timestamp lru replacement and
// dirty flush.
// ----------------------------------------------------------------------------
// usage
// s_* carries one request: s_tuser = mode (put, get, flush), s_tdata holds
// key, handle and length from bit 0 up. m_* returns results; m_tlast marks
// the final result of a request. one request is handled at a time:
// s_tready is high only while the block waits for a new request.
// get and put on a key already present go from lookup straight to the result,
// with no scan. put of a new key first runs the one-slot-per-cycle stamp
// scan for the least recently used slot, then reads that slot.
// flush returns one result per dirty entry, each preceded by a read of the
// handle/length memory; with nothing dirty a single empty result flagged last
// comes back.
// s_tready returns together with the last result, or from the flush search
// once no dirty entry is left after a flush that returned entries.
// reset empties every slot and clears the stamp counter; no clearing pass.
// a stalled m_tready holds the result register and the sequencer waits.
// ----------------------------------------------------------------------------
module lru_keyed_cache_with_dirty_flush_core
    import lkc_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int KEY_WIDTH    = KEY_WIDTH_DEF,
    parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF,
    localparam int S_DATA_W    = ((KEY_WIDTH + HANDLE_WIDTH + LEN_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W    = ((KEY_WIDTH + 2 * HANDLE_WIDTH + LEN_WIDTH + 7) / 8) * 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_DATA_W-1:0]   s_tdata,   // key, handle, length
    input  wire logic [MODE_WIDTH-1:0] s_tuser,   // mode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata,   // out_key, out_handle, out_length,
                                                  // evicted_handle
    output logic [3:0]                 m_tuser,   // hit, entry_valid, evicted_valid,
                                                  // evicted_dirty
    output logic                       m_tlast
);

    localparam int HND_LO = KEY_WIDTH;
    localparam int LEN_LO = KEY_WIDTH + HANDLE_WIDTH;

    lkc_cmd_t                cmd;
    lkc_sts_t                sts;
    logic                    out_hit;
    logic                    out_entry_valid;
    logic [KEY_WIDTH-1:0]    out_key;
    logic [HANDLE_WIDTH-1:0] out_handle;
    logic [LEN_WIDTH-1:0]    out_length;
    logic                    out_evicted_valid;
    logic                    out_evicted_dirty;
    logic [HANDLE_WIDTH-1:0] out_evicted_handle;

    lkc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lkc_datapath #(
        .SLOTS        (SLOTS),
        .KEY_WIDTH    (KEY_WIDTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .in_mode            (s_tuser),
        .in_key             (s_tdata[KEY_WIDTH-1:0]),
        .in_handle          (s_tdata[HND_LO +: HANDLE_WIDTH]),
        .in_length          (s_tdata[LEN_LO +: LEN_WIDTH]),
        .out_ready          (m_tready),
        .out_valid          (m_tvalid),
        .out_hit            (out_hit),
        .out_entry_valid    (out_entry_valid),
        .out_key            (out_key),
        .out_handle         (out_handle),
        .out_length         (out_length),
        .out_evicted_valid  (out_evicted_valid),
        .out_evicted_dirty  (out_evicted_dirty),
        .out_evicted_handle (out_evicted_handle),
        .out_last           (m_tlast)
    );

    assign m_tdata = M_DATA_W'({out_evicted_handle, out_length, out_handle, out_key});
    assign m_tuser = {out_evicted_dirty, out_evicted_valid, out_entry_valid, out_hit};

endmodule
`default_nettype wire
